// ===== hw/rtl/vpm7_pkg.sv =====
// Shared register codes and address remap for the VRAM port and mode-7 multiplier.
`default_nettype none

package vpm7_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_READ  = 1'b1;

	typedef enum logic [7:0] {
		REG_M7_HOFS  = 8'h0D,
		REG_M7_VOFS  = 8'h0E,
		REG_VMAIN    = 8'h15,
		REG_VMADDL   = 8'h16,
		REG_VMADDH   = 8'h17,
		REG_VMDATAL  = 8'h18,
		REG_VMDATAH  = 8'h19,
		REG_M7A      = 8'h1B,
		REG_M7B      = 8'h1C,
		REG_M7C      = 8'h1D,
		REG_M7D      = 8'h1E,
		REG_M7X      = 8'h1F,
		REG_M7Y      = 8'h20,
		REG_MPYL     = 8'h34,
		REG_MPYM     = 8'h35,
		REG_MPYH     = 8'h36
	} reg_addr_t;

	typedef enum logic [1:0] {
		REMAP_NONE  = 2'd0,
		REMAP_8BIT  = 2'd1,
		REMAP_9BIT  = 2'd2,
		REMAP_10BIT = 2'd3
	} remap_t;

	localparam int WordAw = 16;
	localparam int VramAw = 15;

	localparam logic [WordAw-1:0] StepOne  = 16'd1;
	localparam logic [WordAw-1:0] Step32   = 16'd32;
	localparam logic [WordAw-1:0] Step128  = 16'd128;

	// Rotates the low address bits so tile rows land in consecutive words.
	function automatic logic [VramAw-1:0] remap_addr(input logic [WordAw-1:0] w,
		input remap_t mode);
		logic [VramAw-1:0] r;
		case (mode)
			REMAP_8BIT:  r = {w[14:8], w[4:0], w[7:5]};
			REMAP_9BIT:  r = {w[14:9], w[5:0], w[8:6]};
			REMAP_10BIT: r = {w[14:10], w[6:0], w[9:7]};
			default:     r = w[14:0];
		endcase
		return r;
	endfunction

	function automatic logic [WordAw-1:0] step_size(input logic [1:0] code);
		logic [WordAw-1:0] s;
		if (code[1]) begin
			s = Step128;
		end else if (code[0]) begin
			s = Step32;
		end else begin
			s = StepOne;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/vram_port_and_mode7_multiplier.sv =====
// VRAM access port and mode-7 multiplier, top level.
//
// One bus access per input transfer: op (0 write, 1 read), reg_req (low byte
// of a page 0x21 register address) and data (write value, or the bus value
// on reads). Each access gives exactly one output transfer: rd_data holds the
// product byte on reads of 0x34..0x36, the bus value on other reads and zero
// on writes; vram_we/vram_high/vram_word_addr/vram_byte describe the VRAM
// byte write caused by 0x18/0x19 and are zero otherwise.
// Both channels use valid/stall; a transfer happens when valid is high and
// stall is low.
// The path is an input register, then the output register, fed by the address
// remap; the register update and the 16x8 signed multiply write the register
// state. Throughput is one access per cycle while the receiver does not
// stall.
// When the receiver stalls, the output register holds, the input register
// fills, and in_stall rises only once both are occupied.
// Reset clears the pipeline valids and puts the register state in its
// power-up value (increment after high byte, step 1, no remap, address 0,
// matrix and product 0).
`default_nettype none

module vram_port_and_mode7_multiplier (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic        op,
	input  wire logic [7:0]  reg_req,
	input  wire logic [7:0]  data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [7:0]       rd_data,
	output logic             vram_we,
	output logic             vram_high,
	output logic [14:0]      vram_word_addr,
	output logic [7:0]       vram_byte
);

	// input register
	logic        valid_s1;
	logic        op_s1;
	logic [7:0]  reg_s1;
	logic [7:0]  data_s1;

	// register state
	logic                inc_high_q;
	logic [1:0]          step_code_q;
	vpm7_pkg::remap_t    remap_q;
	logic [15:0]         word_addr_q;
	logic [7:0]          buf_q;
	logic [15:0]         mat_a_q;
	logic [7:0]          mul_b_q;
	logic signed [23:0]  product_q;

	logic out_valid_q;
	logic advance;
	logic s1_fire;
	logic in_fire;

	assign advance  = !out_valid_q || !out_stall;
	assign s1_fire  = valid_s1 && advance;
	assign in_stall = valid_s1 && !advance;
	assign in_fire  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (s1_fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			op_s1   <= op;
			reg_s1  <= reg_req;
			data_s1 <= data;
		end
	end

	// decode of the item in the input register
	logic        is_wr;
	logic        is_vram;
	logic        hit_high;
	logic        do_inc;
	logic        is_mat;
	logic        ld_buf;
	logic [15:0] new_a;
	logic [7:0]  new_b;
	logic signed [23:0] prod_next;
	logic [7:0]  rd_next;

	always_comb begin
		is_wr    = (op_s1 == vpm7_pkg::OP_WRITE);
		is_vram  = is_wr && (reg_s1 == vpm7_pkg::REG_VMDATAL || reg_s1 == vpm7_pkg::REG_VMDATAH);
		hit_high = (reg_s1 == vpm7_pkg::REG_VMDATAH);
		do_inc   = is_vram && (hit_high == inc_high_q);
		is_mat   = is_wr && (reg_s1 == vpm7_pkg::REG_M7A || reg_s1 == vpm7_pkg::REG_M7B
			|| reg_s1 == vpm7_pkg::REG_M7C || reg_s1 == vpm7_pkg::REG_M7D);
		ld_buf   = is_mat || (is_wr && (reg_s1 == vpm7_pkg::REG_M7_HOFS
			|| reg_s1 == vpm7_pkg::REG_M7_VOFS || reg_s1 == vpm7_pkg::REG_M7X
			|| reg_s1 == vpm7_pkg::REG_M7Y));
		new_a    = (is_wr && reg_s1 == vpm7_pkg::REG_M7A) ? {data_s1, buf_q} : mat_a_q;
		new_b    = (is_wr && reg_s1 == vpm7_pkg::REG_M7B) ? data_s1 : mul_b_q;
		prod_next = $signed(new_a) * $signed(new_b);

		rd_next = 8'h00;
		if (!is_wr) begin
			case (reg_s1)
				vpm7_pkg::REG_MPYL: rd_next = product_q[7:0];
				vpm7_pkg::REG_MPYM: rd_next = product_q[15:8];
				vpm7_pkg::REG_MPYH: rd_next = product_q[23:16];
				default:            rd_next = data_s1;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inc_high_q  <= 1'b1;
			step_code_q <= 2'd0;
			remap_q     <= vpm7_pkg::REMAP_NONE;
			word_addr_q <= '0;
			buf_q       <= '0;
			mat_a_q     <= '0;
			mul_b_q     <= '0;
			product_q   <= '0;
		end else if (s1_fire && is_wr) begin
			if (reg_s1 == vpm7_pkg::REG_VMAIN) begin
				inc_high_q  <= data_s1[7];
				step_code_q <= data_s1[1:0];
				remap_q     <= vpm7_pkg::remap_t'(data_s1[3:2]);
			end
			if (reg_s1 == vpm7_pkg::REG_VMADDL) begin
				word_addr_q[7:0] <= data_s1;
			end
			if (reg_s1 == vpm7_pkg::REG_VMADDH) begin
				word_addr_q[15:8] <= data_s1;
			end
			if (do_inc) begin
				word_addr_q <= word_addr_q + vpm7_pkg::step_size(step_code_q);
			end
			if (ld_buf) begin
				buf_q <= data_s1;
			end
			if (is_mat) begin
				mat_a_q   <= new_a;
				mul_b_q   <= new_b;
				product_q <= prod_next;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_fire) begin
			rd_data        <= rd_next;
			vram_we        <= is_vram;
			vram_high      <= is_vram && hit_high;
			vram_word_addr <= is_vram ? vpm7_pkg::remap_addr(word_addr_q, remap_q) : '0;
			vram_byte      <= is_vram ? data_s1 : 8'h00;
		end
	end

	assign out_valid = out_valid_q;

	// checks
	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q))
		else $error("input stalled with a free stage");

	a_vram_write_reads_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && vram_we) |-> (rd_data == 8'h00))
		else $error("VRAM write carries read data");

	a_no_vram_fields_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !vram_we) |-> (!vram_high && vram_word_addr == '0 && vram_byte == '0))
		else $error("VRAM fields set without a VRAM write");

	a_addr_moves_on_item: assert property (@(posedge clk) disable iff (!arst_n)
		!s1_fire |=> $stable(word_addr_q))
		else $error("word address changed without an access");

endmodule

`default_nettype wire
